>>> hw/rtl/legik_pkg.sv
// ----------------------------------------------------------------------------
// Leg inverse kinematics package
// Shared widths, register indexes, angle constants and the CORDIC arctangent
// table used by the leg inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package legik_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int LEN_WIDTH       = 15;
    localparam int ANGLE_WIDTH     = 32;
    localparam int OUT_WIDTH       = 16;
    localparam int OPER_WIDTH      = 34;
    localparam int PRESCALE_SHIFT  = 20;
    localparam int ISQ_STAGES      = 32;
    localparam int ISQ_WIDTH       = 64;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic [LEN_WIDTH-1:0] UPPER_LEN_RST = 15'd2560;
    localparam logic [LEN_WIDTH-1:0] LOWER_LEN_RST = 15'd2560;
    localparam logic [LEN_WIDTH-1:0] ZERO_LEN_RST  = 15'd0;

    localparam logic signed [ANGLE_WIDTH-1:0] DEG90  = 32'sd5898240;
    localparam logic signed [ANGLE_WIDTH-1:0] DEG180 = 32'sd11796480;
    localparam logic signed [ANGLE_WIDTH-1:0] ROUND_HALF = 32'sd512;

    typedef enum logic [2:0] {
        REG_UPPER_LEN  = 3'd0,
        REG_LOWER_LEN  = 3'd1,
        REG_SHLD_WIDTH = 3'd2,
        REG_SHLD_LEN   = 3'd3,
        REG_MARGIN     = 3'd4
    } cfg_reg_t;

    function automatic logic signed [ANGLE_WIDTH-1:0] cordic_atan(input int idx);
        logic signed [ANGLE_WIDTH-1:0] val;
        case (idx)
            0:  val = 32'sd2949120;
            1:  val = 32'sd1740967;
            2:  val = 32'sd919879;
            3:  val = 32'sd466945;
            4:  val = 32'sd234379;
            5:  val = 32'sd117304;
            6:  val = 32'sd58666;
            7:  val = 32'sd29335;
            8:  val = 32'sd14668;
            9:  val = 32'sd7334;
            10: val = 32'sd3667;
            11: val = 32'sd1833;
            12: val = 32'sd917;
            13: val = 32'sd458;
            14: val = 32'sd229;
            15: val = 32'sd115;
            16: val = 32'sd57;
            17: val = 32'sd29;
            18: val = 32'sd14;
            19: val = 32'sd7;
            20: val = 32'sd4;
            21: val = 32'sd2;
            22: val = 32'sd1;
            default: val = 32'sd0;
        endcase
        return val;
    endfunction

endpackage

>>> hw/rtl/leg_inverse_kinematics_3dof_top.sv
// ----------------------------------------------------------------------------
// Three-link leg inverse kinematics
// Takes one foot target per clock and returns shoulder, hip and knee angles
// in 1/64 degree with a reachability flag. The block accepts a target in
// every cycle and busy never rises. Each result reaches done through seven
// arithmetic stages, the 32-stage square root pipeline, the CORDIC pipeline
// of one pre-rotation and CORDIC_STAGES micro-rotations, and the output
// register. Leg geometry must be written over the APB port while idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics_3dof_top #(
    parameter int CORDIC_STAGES = legik_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [4:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [legik_pkg::COORD_WIDTH-1:0] target_fwd,
    input  logic signed [legik_pkg::COORD_WIDTH-1:0] target_lat,
    input  logic signed [legik_pkg::COORD_WIDTH-1:0] target_vert,
    output logic                                    done,
    output logic signed [legik_pkg::OUT_WIDTH-1:0]  shoulder_deg,
    output logic signed [legik_pkg::OUT_WIDTH-1:0]  hip_deg,
    output logic signed [legik_pkg::OUT_WIDTH-1:0]  knee_deg,
    output logic                                    reachable
);

    localparam int CW  = legik_pkg::COORD_WIDTH;
    localparam int LW  = legik_pkg::LEN_WIDTH;
    localparam int OW  = legik_pkg::OPER_WIDTH;
    localparam int AW  = legik_pkg::ANGLE_WIDTH;
    localparam int NQ  = legik_pkg::ISQ_STAGES;
    localparam int LATENCY = 7 + NQ + 1 + CORDIC_STAGES + 1;

    typedef struct packed {
        logic                 ok;
        logic signed [OW-1:0] n1;
        logic signed [OW-1:0] n2;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } side_t;

    // Configuration registers.
    logic [LW-1:0] upper_reg;
    logic [LW-1:0] lower_reg;
    logic [LW-1:0] width_reg;
    logic [LW-1:0] slen_reg;
    logic [LW-1:0] margin_reg;
    logic          cfg_write;
    legik_pkg::cfg_reg_t cfg_sel;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = legik_pkg::cfg_reg_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= legik_pkg::UPPER_LEN_RST;
            lower_reg  <= legik_pkg::LOWER_LEN_RST;
            width_reg  <= legik_pkg::ZERO_LEN_RST;
            slen_reg   <= legik_pkg::ZERO_LEN_RST;
            margin_reg <= legik_pkg::ZERO_LEN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                legik_pkg::REG_UPPER_LEN:  upper_reg  <= pwdata[LW-1:0];
                legik_pkg::REG_LOWER_LEN:  lower_reg  <= pwdata[LW-1:0];
                legik_pkg::REG_SHLD_WIDTH: width_reg  <= pwdata[LW-1:0];
                legik_pkg::REG_SHLD_LEN:   slen_reg   <= pwdata[LW-1:0];
                legik_pkg::REG_MARGIN:     margin_reg <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            legik_pkg::REG_UPPER_LEN:  prdata = {17'd0, upper_reg};
            legik_pkg::REG_LOWER_LEN:  prdata = {17'd0, lower_reg};
            legik_pkg::REG_SHLD_WIDTH: prdata = {17'd0, width_reg};
            legik_pkg::REG_SHLD_LEN:   prdata = {17'd0, slen_reg};
            legik_pkg::REG_MARGIN:     prdata = {17'd0, margin_reg};
            default:                   prdata = '0;
        endcase
    end

    // Geometry terms derived from the registers, refreshed every cycle.
    logic [29:0]        uu_reg;
    logic [29:0]        ll_reg;
    logic [29:0]        ul_reg;
    logic [31:0]        sumsq_reg;
    logic [29:0]        diffsq_reg;
    logic [29:0]        w2_reg;
    logic               hi_neg_reg;
    logic [34:0]        hisq_reg;
    logic [33:0]        losq_reg;
    logic               degen_reg;
    logic [30:0]        uupll_reg;
    logic signed [30:0] uumll_reg;
    logic [31:0]        uu4_reg;
    logic [63:0]        d1sq_reg;

    logic [LW:0]          len_sum;
    logic [LW-1:0]        len_diff;
    logic signed [18:0]   bound_hi;
    logic signed [37:0]   bound_hi_sq;
    logic [17:0]          bound_lo;

    always_comb
    begin
        len_sum  = {1'b0, upper_reg} + {1'b0, lower_reg};
        len_diff = (upper_reg > lower_reg) ? upper_reg - lower_reg : lower_reg - upper_reg;
        bound_hi = $signed({3'b0, len_sum}) - $signed({4'b0, margin_reg})
                 + $signed({3'b0, slen_reg, 1'b0});
        bound_hi_sq = bound_hi * bound_hi;
        bound_lo = {3'b0, len_diff} + {2'b0, slen_reg, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        uu_reg     <= upper_reg * upper_reg;
        ll_reg     <= lower_reg * lower_reg;
        ul_reg     <= upper_reg * lower_reg;
        sumsq_reg  <= 32'(len_sum) * 32'(len_sum);
        diffsq_reg <= len_diff * len_diff;
        w2_reg     <= width_reg * width_reg;
        hi_neg_reg <= bound_hi[18];
        hisq_reg   <= bound_hi_sq[34:0];
        losq_reg   <= 34'(bound_lo) * 34'(bound_lo);
        degen_reg  <= (upper_reg == '0) || (lower_reg == '0);
        uupll_reg  <= {1'b0, uu_reg} + {1'b0, ll_reg};
        uumll_reg  <= $signed({1'b0, uu_reg}) - $signed({1'b0, ll_reg});
        uu4_reg    <= {uu_reg, 2'b00};
        d1sq_reg   <= (64'(ul_reg) * 64'(ul_reg)) << 2;
    end

    // Valid bits for the arithmetic stages.
    logic [7:1] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[6:1], start && !busy};
        end
    end

    // Stage 1: capture the target.
    logic signed [CW-1:0] x1_reg, y1_reg, z1_reg;

    always_ff @(posedge clk)
    begin
        x1_reg <= target_fwd;
        y1_reg <= target_lat;
        z1_reg <= target_vert;
    end

    // Stage 2: squares of the coordinates.
    logic signed [CW-1:0]   x2_reg, y2_reg, z2_reg;
    logic [2*CW-2:0]        xx2_reg, yy2_reg, zz2_reg;
    logic signed [2*CW-1:0] xx_next, yy_next, zz_next;

    always_comb
    begin
        xx_next = x1_reg * x1_reg;
        yy_next = y1_reg * y1_reg;
        zz_next = z1_reg * z1_reg;
    end

    always_ff @(posedge clk)
    begin
        x2_reg  <= x1_reg;
        y2_reg  <= y1_reg;
        z2_reg  <= z1_reg;
        xx2_reg <= xx_next[2*CW-2:0];
        yy2_reg <= yy_next[2*CW-2:0];
        zz2_reg <= zz_next[2*CW-2:0];
    end

    // Stage 3: X-Z and Y-Z squared reach.
    logic signed [CW-1:0] x3_reg, y3_reg, z3_reg;
    logic [31:0]          r2_3_reg, yz2_3_reg;

    always_ff @(posedge clk)
    begin
        x3_reg    <= x2_reg;
        y3_reg    <= y2_reg;
        z3_reg    <= z2_reg;
        r2_3_reg  <= {1'b0, xx2_reg} + {1'b0, zz2_reg};
        yz2_3_reg <= {1'b0, yy2_reg} + {1'b0, zz2_reg};
    end

    // Stage 4: reach checks and law of cosines numerators.
    logic signed [CW-1:0] x4_reg, y4_reg, z4_reg;
    logic [31:0]          r2_4_reg;
    logic                 ok4_reg;
    logic signed [OW-1:0] n1_4_reg, n2_4_reg;
    logic [31:0]          dcorr;
    logic                 ok_next;

    always_comb
    begin
        dcorr = (yz2_3_reg >= {2'b0, w2_reg}) ? yz2_3_reg - {2'b0, w2_reg} : '0;
        ok_next = !(r2_3_reg > sumsq_reg)
               && !(r2_3_reg < {2'b0, diffsq_reg})
               && !(yz2_3_reg < {2'b0, w2_reg})
               && !hi_neg_reg
               && !({3'b0, dcorr} > hisq_reg)
               && !({2'b0, dcorr} < losq_reg)
               && !degen_reg
               && (r2_3_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        x4_reg   <= x3_reg;
        y4_reg   <= y3_reg;
        z4_reg   <= z3_reg;
        r2_4_reg <= r2_3_reg;
        ok4_reg  <= ok_next;
        n1_4_reg <= $signed({3'b0, uupll_reg}) - $signed({2'b0, r2_3_reg});
        n2_4_reg <= $signed({{3{uumll_reg[30]}}, uumll_reg}) + $signed({2'b0, r2_3_reg});
    end

    // Stage 5: magnitudes of the numerators.
    side_t       s5_reg;
    logic [31:0] r2_5_reg;
    logic [31:0] a1_reg, a2_reg;
    logic signed [OW-1:0] n1_neg, n2_neg;

    assign n1_neg = -n1_4_reg;
    assign n2_neg = -n2_4_reg;

    always_ff @(posedge clk)
    begin
        s5_reg   <= '{ok: ok4_reg, n1: n1_4_reg, n2: n2_4_reg,
                      x: x4_reg, y: y4_reg, z: z4_reg};
        r2_5_reg <= r2_4_reg;
        a1_reg   <= n1_4_reg[OW-1] ? n1_neg[31:0] : n1_4_reg[31:0];
        a2_reg   <= n2_4_reg[OW-1] ? n2_neg[31:0] : n2_4_reg[31:0];
    end

    // Stage 6: squared numerators and squared hip denominator.
    side_t       s6_reg;
    logic [63:0] asq1_reg, asq2_reg, d2sq_reg;

    always_ff @(posedge clk)
    begin
        s6_reg   <= s5_reg;
        asq1_reg <= 64'(a1_reg) * 64'(a1_reg);
        asq2_reg <= 64'(a2_reg) * 64'(a2_reg);
        d2sq_reg <= 64'(uu4_reg) * 64'(r2_5_reg);
    end

    // Stage 7: sine terms squared, clamped at zero.
    side_t       s7_reg;
    logic [63:0] rem1_reg, rem2_reg;

    always_ff @(posedge clk)
    begin
        s7_reg   <= s6_reg;
        rem1_reg <= (asq1_reg <= d1sq_reg) ? d1sq_reg - asq1_reg : '0;
        rem2_reg <= (asq2_reg <= d2sq_reg) ? d2sq_reg - asq2_reg : '0;
    end

    logic [NQ-1:0] root1, root2;

    legik_isqrt u_isqrt_knee (
        .clk   (clk),
        .value (rem1_reg),
        .root  (root1)
    );

    legik_isqrt u_isqrt_hip (
        .clk   (clk),
        .value (rem2_reg),
        .root  (root2)
    );

    // Side data and valid bits alongside the square root pipeline.
    side_t         sq_side_reg [0:NQ-1];
    logic [NQ-1:0] sq_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg <= '0;
        end
        else
        begin
            sq_v_reg <= {sq_v_reg[NQ-2:0], v_reg[7]};
        end
    end

    always_ff @(posedge clk)
    begin
        sq_side_reg[0] <= s7_reg;
        for (int k = 1; k < NQ; k++)
        begin
            sq_side_reg[k] <= sq_side_reg[k-1];
        end
    end

    side_t                sq_out;
    logic signed [OW-1:0] neg_z;
    logic signed [AW-1:0] ang_knee, ang_hip, ang_shld, ang_fwd;

    assign sq_out = sq_side_reg[NQ-1];
    assign neg_z  = -{{(OW-CW){sq_out.z[CW-1]}}, sq_out.z};

    legik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_knee (
        .clk   (clk),
        .y_in  ({{(OW-NQ){1'b0}}, root1}),
        .x_in  (sq_out.n1),
        .angle (ang_knee)
    );

    legik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_hip (
        .clk   (clk),
        .y_in  ({{(OW-NQ){1'b0}}, root2}),
        .x_in  (sq_out.n2),
        .angle (ang_hip)
    );

    legik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_shld (
        .clk   (clk),
        .y_in  ({{(OW-CW){sq_out.y[CW-1]}}, sq_out.y}),
        .x_in  (neg_z),
        .angle (ang_shld)
    );

    legik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_fwd (
        .clk   (clk),
        .y_in  ({{(OW-CW){sq_out.x[CW-1]}}, sq_out.x}),
        .x_in  (neg_z),
        .angle (ang_fwd)
    );

    // Valid and reach flags alongside the CORDIC pipeline.
    logic [CORDIC_STAGES:0] cd_v_reg;
    logic [CORDIC_STAGES:0] cd_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_v_reg <= '0;
        end
        else
        begin
            cd_v_reg <= {cd_v_reg[CORDIC_STAGES-1:0], sq_v_reg[NQ-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        cd_ok_reg <= {cd_ok_reg[CORDIC_STAGES-1:0], sq_out.ok};
    end

    // Output stage: joint angles, rounded to 1/64 degree.
    logic signed [AW-1:0] shld_fine, hip_fine, knee_fine;
    logic                 ok_out;
    logic                 done_reg;
    logic                 reach_reg;
    logic signed [legik_pkg::OUT_WIDTH-1:0] shld_reg, hip_reg, knee_reg;

    always_comb
    begin
        ok_out    = cd_ok_reg[CORDIC_STAGES];
        shld_fine = ang_shld + legik_pkg::DEG90 + legik_pkg::ROUND_HALF;
        hip_fine  = ang_hip - ang_fwd + legik_pkg::ROUND_HALF;
        knee_fine = ang_knee - legik_pkg::DEG180 + legik_pkg::ROUND_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cd_v_reg[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        reach_reg <= ok_out;
        shld_reg  <= ok_out ? shld_fine[25:10] : '0;
        hip_reg   <= ok_out ? hip_fine[25:10] : '0;
        knee_reg  <= ok_out ? knee_fine[25:10] : '0;
    end

    assign done         = done_reg;
    assign reachable    = reach_reg;
    assign shoulder_deg = shld_reg;
    assign hip_deg      = hip_reg;
    assign knee_deg     = knee_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("Accepted transaction did not produce a result on time.");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("Result appeared without a matching transaction.");

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !reachable) |-> (shoulder_deg == '0 && hip_deg == '0 && knee_deg == '0))
        else $error("Unreachable result carries nonzero angles.");

endmodule

>>> hw/rtl/legik_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit unsigned value, one result bit per stage.
// ----------------------------------------------------------------------------
module legik_isqrt (
    input  logic                                clk,
    input  logic [legik_pkg::ISQ_WIDTH-1:0]     value,
    output logic [legik_pkg::ISQ_STAGES-1:0]    root
);

    localparam int N = legik_pkg::ISQ_STAGES;
    localparam int W = legik_pkg::ISQ_WIDTH;

    logic [W-1:0] rem_reg [1:N];
    logic [W-1:0] res_reg [1:N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
        logic [W-1:0] rem_cur;
        logic [W-1:0] res_cur;
        logic [W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign rem_cur = value;
            assign res_cur = '0;
        end
        else
        begin : g_later
            assign rem_cur = rem_reg[k];
            assign res_cur = res_reg[k];
        end

        assign trial = res_cur + BIT;

        always_ff @(posedge clk)
        begin
            if (rem_cur >= trial)
            begin
                rem_reg[k+1] <= rem_cur - trial;
                res_reg[k+1] <= (res_cur >> 1) + BIT;
            end
            else
            begin
                rem_reg[k+1] <= rem_cur;
                res_reg[k+1] <= res_cur >> 1;
            end
        end
    end

    assign root = res_reg[N][N-1:0];

endmodule

>>> hw/rtl/legik_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC arctangent
// Vectoring-mode atan2(y, x) in 2^-16 degree, with quarter-turn pre-rotation
// and one micro-rotation per stage. A zero vector gives an angle of zero.
// ----------------------------------------------------------------------------
module legik_cordic #(
    parameter int STAGES = legik_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                        clk,
    input  logic signed [legik_pkg::OPER_WIDTH-1:0]     y_in,
    input  logic signed [legik_pkg::OPER_WIDTH-1:0]     x_in,
    output logic signed [legik_pkg::ANGLE_WIDTH-1:0]    angle
);

    localparam int IW = legik_pkg::OPER_WIDTH;
    localparam int W  = IW + legik_pkg::PRESCALE_SHIFT + 4;
    localparam int AW = legik_pkg::ANGLE_WIDTH;

    logic signed [W-1:0]  xs_reg   [0:STAGES];
    logic signed [W-1:0]  ys_reg   [0:STAGES];
    logic signed [AW-1:0] ang_reg  [0:STAGES];
    logic                 zero_reg [0:STAGES];

    logic signed [W-1:0]  xe;
    logic signed [W-1:0]  ye;
    logic signed [W-1:0]  xs_next;
    logic signed [W-1:0]  ys_next;
    logic signed [AW-1:0] ang_next;

    always_comb
    begin
        xe = {{(W - IW){x_in[IW-1]}}, x_in} <<< legik_pkg::PRESCALE_SHIFT;
        ye = {{(W - IW){y_in[IW-1]}}, y_in} <<< legik_pkg::PRESCALE_SHIFT;
        xs_next  = xe;
        ys_next  = ye;
        ang_next = '0;
        if (xe < 0)
        begin
            if (ye >= 0)
            begin
                xs_next  = ye;
                ys_next  = -xe;
                ang_next = legik_pkg::DEG90;
            end
            else
            begin
                xs_next  = -ye;
                ys_next  = xe;
                ang_next = -legik_pkg::DEG90;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        xs_reg[0]   <= xs_next;
        ys_reg[0]   <= ys_next;
        ang_reg[0]  <= ang_next;
        zero_reg[0] <= (x_in == '0) && (y_in == '0);
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;

        assign dx = xs_reg[i] >>> i;
        assign dy = ys_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            if (ys_reg[i] > 0)
            begin
                xs_reg[i+1]  <= xs_reg[i] + dy;
                ys_reg[i+1]  <= ys_reg[i] - dx;
                ang_reg[i+1] <= ang_reg[i] + legik_pkg::cordic_atan(i);
            end
            else
            begin
                xs_reg[i+1]  <= xs_reg[i] - dy;
                ys_reg[i+1]  <= ys_reg[i] + dx;
                ang_reg[i+1] <= ang_reg[i] - legik_pkg::cordic_atan(i);
            end
        end
    end

    assign angle = zero_reg[STAGES] ? '0 : ang_reg[STAGES];

endmodule
